@@ sv/zohr_pkg.sv @@
// Shared types, constants and register map of the zero-order-hold resampler.
// No dependencies; every other file of the block imports this package.
package zohr_pkg;

    localparam int MAX_REPEAT_DEF = 8;

    localparam int SAMPLE_W = 16;
    localparam int RATE_W   = 18;
    localparam int REM_W    = 21;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    // Byte addresses of the configuration registers.
    localparam logic [ADDR_W-1:0] ADDR_SRC_IS_8BIT = 5'h00;
    localparam logic [ADDR_W-1:0] ADDR_SRC_IS_MONO = 5'h04;
    localparam logic [ADDR_W-1:0] ADDR_DST_IS_8BIT = 5'h08;
    localparam logic [ADDR_W-1:0] ADDR_DST_IS_MONO = 5'h0C;
    localparam logic [ADDR_W-1:0] ADDR_TARGET_RATE = 5'h10;
    localparam logic [ADDR_W-1:0] ADDR_SOURCE_RATE = 5'h14;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic                       first_of_buffer;
    } src_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic                       last;
    } dst_item_t;

    typedef struct packed {
        logic              src_is_8bit;
        logic              src_is_mono;
        logic              dst_is_8bit;
        logic              dst_is_mono;
        logic [RATE_W-1:0] target_rate;
        logic [RATE_W-1:0] source_rate;
    } cfg_t;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic has_copy;
        logic last_copy;
        logic out_free;
    } dp_status_t;

endpackage

@@ sv/zohr_regs.sv @@
// Configuration register file with an APB-style access port.
// Depends on zohr_pkg for the register map and the cfg_t type.
module zohr_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zohr_pkg::ADDR_W-1:0]   paddr,
    input  logic [zohr_pkg::DATA_W-1:0]   pwdata,
    output logic [zohr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output zohr_pkg::cfg_t                cfg
);
    import zohr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr)
                ADDR_SRC_IS_8BIT: cfg_next.src_is_8bit = pwdata[0];
                ADDR_SRC_IS_MONO: cfg_next.src_is_mono = pwdata[0];
                ADDR_DST_IS_8BIT: cfg_next.dst_is_8bit = pwdata[0];
                ADDR_DST_IS_MONO: cfg_next.dst_is_mono = pwdata[0];
                ADDR_TARGET_RATE: cfg_next.target_rate = pwdata[RATE_W-1:0];
                ADDR_SOURCE_RATE: cfg_next.source_rate = pwdata[RATE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_is_8bit <= 1'b0;
            cfg_reg.src_is_mono <= 1'b0;
            cfg_reg.dst_is_8bit <= 1'b0;
            cfg_reg.dst_is_mono <= 1'b0;
            cfg_reg.target_rate <= RATE_RESET;
            cfg_reg.source_rate <= RATE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_SRC_IS_8BIT: prdata = DATA_W'(cfg_reg.src_is_8bit);
            ADDR_SRC_IS_MONO: prdata = DATA_W'(cfg_reg.src_is_mono);
            ADDR_DST_IS_8BIT: prdata = DATA_W'(cfg_reg.dst_is_8bit);
            ADDR_DST_IS_MONO: prdata = DATA_W'(cfg_reg.dst_is_mono);
            ADDR_TARGET_RATE: prdata = DATA_W'(cfg_reg.target_rate);
            ADDR_SOURCE_RATE: prdata = DATA_W'(cfg_reg.source_rate);
            default:          prdata = '0;
        endcase
    end

endmodule

@@ sv/zohr_ctrl.sv @@
// Controller state machine: takes a source item, then paces out its copies.
// Depends on zohr_pkg for the state, command and status types.
module zohr_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  zohr_pkg::dp_status_t status,
    output zohr_pkg::ctrl_cmd_t  cmd
);
    import zohr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        src_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                src_stall = 1'b0;
                if (src_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // A frame that earns no copy only updates the remainder.
                if (!status.has_copy)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_copy)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sv/zohr_datapath.sv @@
// Datapath: sample format conversion, rate remainder, copy counter and output register.
// Depends on zohr_pkg; driven by commands from zohr_ctrl.
module zohr_datapath
#(
    parameter int MAX_REPEAT = zohr_pkg::MAX_REPEAT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  zohr_pkg::cfg_t       cfg,
    input  zohr_pkg::src_item_t  src_item,
    input  zohr_pkg::ctrl_cmd_t  cmd,
    output zohr_pkg::dp_status_t status,
    output logic                 dst_valid,
    input  logic                 dst_stall,
    output zohr_pkg::dst_item_t  dst_item
);
    import zohr_pkg::*;

    localparam int CNT_W = $clog2(MAX_REPEAT + 1);

    function automatic logic signed [SAMPLE_W-1:0] widen
    (
        input logic                       is_8bit,
        input logic signed [SAMPLE_W-1:0] raw
    );
        if (is_8bit)
        begin
            return {~raw[7], raw[6:0], 8'h00};
        end
        return raw;
    endfunction

    // Division by 256 truncates toward zero, so negative values with a
    // non-zero low byte round up by one before the offset is applied.
    function automatic logic signed [SAMPLE_W-1:0] narrow
    (
        input logic                       is_8bit,
        input logic signed [SAMPLE_W-1:0] v
    );
        logic [8:0] q;
        q = {v[15], v[15:8]} + {8'h00, (v[15] && (v[7:0] != 8'h00))};
        if (is_8bit)
        begin
            return {8'h00, q[7:0] ^ 8'h80};
        end
        return v;
    endfunction

    logic signed [SAMPLE_W-1:0] left_w;
    logic signed [SAMPLE_W-1:0] right_w;
    logic signed [SAMPLE_W-1:0] left_n;
    logic signed [SAMPLE_W-1:0] right_n;

    logic signed [SAMPLE_W-1:0] hold_left_reg;
    logic signed [SAMPLE_W-1:0] hold_right_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [REM_W-1:0]           rem_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    dst_item_t                  out_item_reg;

    logic [RATE_W-1:0] srate;
    logic [REM_W-1:0]  srate_w;
    logic [REM_W-1:0]  diff;
    logic              diff_ge;
    logic              cnt_full;

    assign left_w  = widen(cfg.src_is_8bit, src_item.in_left);
    assign right_w = cfg.src_is_mono ? left_w : widen(cfg.src_is_8bit, src_item.in_right);
    assign left_n  = narrow(cfg.dst_is_8bit, left_w);
    assign right_n = cfg.dst_is_mono ? left_n : narrow(cfg.dst_is_8bit, right_w);

    assign srate    = (cfg.source_rate == '0) ? RATE_W'(1) : cfg.source_rate;
    assign srate_w  = REM_W'(srate);
    assign diff     = rem_reg - srate_w;
    assign diff_ge  = diff >= srate_w;
    assign cnt_full = cnt_reg == CNT_W'(MAX_REPEAT - 1);

    assign status.has_copy  = rem_reg >= srate_w;
    assign status.last_copy = !diff_ge || cnt_full;
    assign status.out_free  = !out_valid_reg || !dst_stall;

    always_comb
    begin
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && dst_stall;
        if (cmd.load)
        begin
            rem_next = (src_item.first_of_buffer ? '0 : rem_reg) + REM_W'(cfg.target_rate);
            cnt_next = '0;
        end
        else if (cmd.emit)
        begin
            // At the copy limit any surplus is dropped.
            rem_next       = (cnt_full && diff_ge) ? (srate_w - REM_W'(1)) : diff;
            cnt_next       = cnt_reg + CNT_W'(1);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hold_left_reg  <= left_n;
            hold_right_reg <= right_n;
        end
        if (cmd.emit)
        begin
            out_item_reg.out_left  <= hold_left_reg;
            out_item_reg.out_right <= hold_right_reg;
            out_item_reg.last      <= status.last_copy;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_item  = out_item_reg;

endmodule

@@ sv/pcm_zero_order_hold_resampler_top.sv @@
// Zero-order-hold PCM resampler. Each source item is first taken to update the
// rate remainder and then paced out as its target copies, at most MAX_REPEAT of
// them; an item that earns no copy still passes through the emit state once. The
// single remainder subtract-and-compare step produces one copy per cycle while
// the result side does not stall; a stall on the result side holds it. The last
// copy sits in the output register while the next item is already taken.
// Depends on zohr_pkg, zohr_regs, zohr_ctrl and zohr_datapath.
module pcm_zero_order_hold_resampler_top
#(
    parameter int MAX_REPEAT = zohr_pkg::MAX_REPEAT_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        src_valid,
    output logic                        src_stall,
    input  zohr_pkg::src_item_t         src_item,
    output logic                        dst_valid,
    input  logic                        dst_stall,
    output zohr_pkg::dst_item_t         dst_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [zohr_pkg::ADDR_W-1:0] paddr,
    input  logic [zohr_pkg::DATA_W-1:0] pwdata,
    output logic [zohr_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import zohr_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    zohr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    zohr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .status    (status),
        .cmd       (cmd)
    );

    zohr_datapath #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .src_item  (src_item),
        .cmd       (cmd),
        .status    (status),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_item  (dst_item)
    );

endmodule

@@ sv/zohr_checker.sv @@
// Port-level checks of the resampler's item ordering, bound to the top level.
// Depends on zohr_pkg for the item types.
module zohr_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                src_valid,
    input logic                src_stall,
    input logic                dst_valid,
    input logic                dst_stall,
    input zohr_pkg::dst_item_t dst_item
);
    import zohr_pkg::*;

    // A held result stays in place until it is taken.
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
        else $error("result item changed while stalled");

    // After taking an item the block is busy with its copies.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> src_stall)
        else $error("source item accepted while the previous one was in progress");

    // While a copy that is not the last waits, the frame is unfinished.
    a_stall_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_item.last |-> src_stall)
        else $error("new source item possible before its frame's last copy");

    // A taken copy that is not the last is followed at once by the next one.
    a_next_copy: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_stall && !dst_item.last |=> dst_valid)
        else $error("copy sequence broke off before its last copy");

endmodule

bind pcm_zero_order_hold_resampler_top zohr_checker u_zohr_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
);

@@ tb/pcm_zero_order_hold_resampler_top_test.sv @@
// Self-checking testbench for pcm_zero_order_hold_resampler_top: it predicts
// every target frame from each accepted source frame and the register settings.
// Depends on zohr_pkg and the resampler RTL only.
`timescale 1ns / 100ps

module pcm_zero_order_hold_resampler_top_test;

    import zohr_pkg::*;

    localparam int COPY_LIMIT   = MAX_REPEAT_DEF;
    localparam int DRAIN_CYCLES = 3 * COPY_LIMIT;

    // Predicts the target frames of each source frame and holds them until they
    // come out of the block.
    class copy_predictor;
        cfg_t            settings;
        logic [REM_W-1:0] rate_rem;
        dst_item_t       expected_copies[$];
        int              errors;

        function new();
            settings.src_is_8bit = 1'b0;
            settings.src_is_mono = 1'b0;
            settings.dst_is_8bit = 1'b0;
            settings.dst_is_mono = 1'b0;
            settings.target_rate = RATE_RESET;
            settings.source_rate = RATE_RESET;
            rate_rem = '0;
            errors = 0;
        endfunction

        function int widen(logic [SAMPLE_W-1:0] raw);
            if (settings.src_is_8bit)
                return (int'(raw[7:0]) - 128) * 256;
            return int'($signed(raw));
        endfunction

        function logic [SAMPLE_W-1:0] narrow(int v);
            int byte_val;
            byte_val = v / 256 + 128;
            if (settings.dst_is_8bit)
                return byte_val[SAMPLE_W-1:0];
            return v[SAMPLE_W-1:0];
        endfunction

        function void note_frame(src_item_t it);
            int        left_v;
            int        right_v;
            int        step;
            int        rem;
            int        count;
            dst_item_t copy;
            left_v  = widen(it.in_left);
            right_v = settings.src_is_mono ? left_v : widen(it.in_right);
            step    = (settings.source_rate == '0) ? 1 : int'(settings.source_rate);
            rem     = it.first_of_buffer ? 0 : int'(rate_rem);
            rem     = rem + int'(settings.target_rate);
            count   = 0;
            while (rem >= step && count < COPY_LIMIT)
            begin
                rem = rem - step;
                count++;
            end
            // Surplus beyond the copy limit is thrown away.
            if (rem >= step)
                rem = step - 1;
            rate_rem = rem[REM_W-1:0];
            copy.out_left  = narrow(left_v);
            copy.out_right = settings.dst_is_mono ? copy.out_left : narrow(right_v);
            for (int k = 0; k < count; k++)
            begin
                copy.last = (k == count - 1);
                expected_copies.push_back(copy);
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t ns: mismatch: %s", $time, msg);
        endtask

        task check_copy(dst_item_t got);
            dst_item_t want;
            if (expected_copies.size() == 0)
            begin
                report_mismatch($sformatf("unexpected target frame %h", got));
                return;
            end
            want = expected_copies.pop_front();
            if (got.out_left !== want.out_left)
                report_mismatch($sformatf("out_left %h, expected %h",
                                          got.out_left, want.out_left));
            if (got.out_right !== want.out_right)
                report_mismatch($sformatf("out_right %h, expected %h",
                                          got.out_right, want.out_right));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
        endtask

        function int pending();
            return expected_copies.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                src_valid;
    logic                src_stall;
    src_item_t           src_item;
    logic                dst_valid;
    logic                dst_stall;
    dst_item_t           dst_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    bit                  steady;
    copy_predictor       copies;
    int                  common_rates[9] = '{8000, 11025, 16000, 22050, 32000,
                                             44100, 48000, 96000, 192000};

    pcm_zero_order_hold_resampler_top #(
        .MAX_REPEAT(COPY_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .src_item(src_item),
        .dst_valid(dst_valid),
        .dst_stall(dst_stall),
        .dst_item(dst_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none while steady is set.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] corner[7] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                           16'h0080, 16'h007F, 16'h00FF};
        if ($urandom_range(0, 9) == 0)
            return corner[$urandom_range(0, 6)];
        return SAMPLE_W'($urandom());
    endfunction

    function automatic int pick_rate();
        if ($urandom_range(0, 9) < 7)
            return common_rates[$urandom_range(0, 8)];
        return $urandom_range(1, 192000);
    endfunction

    function automatic src_item_t make_frame(logic [SAMPLE_W-1:0] l,
                                             logic [SAMPLE_W-1:0] r, bit f);
        src_item_t it;
        it.in_left = l;
        it.in_right = r;
        it.first_of_buffer = f;
        return it;
    endfunction

    function automatic cfg_t make_cfg(bit s8, bit sm, bit d8, bit dm, int t, int s);
        cfg_t c;
        c.src_is_8bit = s8;
        c.src_is_mono = sm;
        c.dst_is_8bit = d8;
        c.dst_is_mono = dm;
        c.target_rate = t[RATE_W-1:0];
        c.source_rate = s[RATE_W-1:0];
        return c;
    endfunction

    // Result side: stall pattern changes at the falling edge.
    initial
    begin
        int hold;
        hold = 0;
        dst_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                dst_stall = 1'b1;
                hold--;
            end
            else
            begin
                dst_stall = 1'b0;
                hold = idle_len();
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && dst_valid && !dst_stall)
                copies.check_copy(dst_item);
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task apply_settings(input cfg_t c);
        write_reg(ADDR_SRC_IS_8BIT, DATA_W'(c.src_is_8bit));
        write_reg(ADDR_SRC_IS_MONO, DATA_W'(c.src_is_mono));
        write_reg(ADDR_DST_IS_8BIT, DATA_W'(c.dst_is_8bit));
        write_reg(ADDR_DST_IS_MONO, DATA_W'(c.dst_is_mono));
        write_reg(ADDR_TARGET_RATE, DATA_W'(c.target_rate));
        write_reg(ADDR_SOURCE_RATE, DATA_W'(c.source_rate));
        copies.settings = c;
    endtask

    // A source frame held on the bus until it is taken; the valid stays high
    // into the next item when no gap is drawn.
    task send_frame(input src_item_t it);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            src_valid = 1'b0;
            src_item = {$urandom(), 1'b0};
            repeat (gap) @(negedge clk);
        end
        src_valid = 1'b1;
        src_item = it;
        do @(posedge clk); while (src_stall);
        copies.note_frame(it);
        @(negedge clk);
    endtask

    // A frame that earns no copy may still be inside the block when the queue
    // runs dry, hence the extra cycles.
    task settle();
        src_valid = 1'b0;
        while (copies.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        cfg_t c;
        rst_n = 1'b0;
        src_valid = 1'b0;
        src_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        steady = 1'b0;
        copies = new();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // Reset settings: one 16-bit stereo copy per frame.
        send_frame(make_frame(16'h7FFF, 16'h8000, 1'b1));
        send_frame(make_frame(16'h8000, 16'h7FFF, 1'b0));
        send_frame(make_frame(16'h0000, 16'hFFFF, 1'b0));
        send_frame(make_frame(16'h00FF, 16'hFF00, 1'b1));

        // 8-bit mono source to 8-bit stereo; upper input bits must be ignored.
        settle();
        apply_settings(make_cfg(1, 1, 1, 0, 48000, 44100));
        send_frame(make_frame(16'h00FF, 16'h1234, 1'b1));
        send_frame(make_frame(16'hFF00, 16'h0000, 1'b0));
        send_frame(make_frame(16'h0080, 16'h007F, 1'b0));
        send_frame(make_frame(16'hAB01, 16'hFFFF, 1'b0));

        // Count saturation: the remainder is clipped after MAX_REPEAT copies.
        settle();
        apply_settings(make_cfg(1, 0, 0, 1, 192000, 1));
        send_frame(make_frame(16'h0000, 16'h00FF, 1'b0));
        send_frame(make_frame(16'h7F80, 16'h8001, 1'b1));

        // Zero target rate with a zero source rate: nothing comes out.
        settle();
        apply_settings(make_cfg(0, 0, 0, 0, 0, 0));
        send_frame(make_frame(16'h1234, 16'h5678, 1'b1));
        send_frame(make_frame(16'h8000, 16'h7FFF, 1'b0));

        // A zero source rate counts as one.
        settle();
        apply_settings(make_cfg(0, 1, 0, 0, 3, 0));
        send_frame(make_frame(16'hFFFF, 16'h0001, 1'b0));
        send_frame(make_frame(16'h4000, 16'hC000, 1'b1));

        // Tiny ratio: frames that earn no copy at all.
        settle();
        apply_settings(make_cfg(0, 0, 0, 0, 1, 192000));
        send_frame(make_frame(16'h0101, 16'h0202, 1'b1));
        send_frame(make_frame(16'h0303, 16'h0404, 1'b0));
        send_frame(make_frame(16'h0505, 16'h0606, 1'b1));

        // Widest rate fields; 16-bit to 8-bit narrowing around zero.
        settle();
        apply_settings(make_cfg(0, 0, 1, 0, 262143, 262143));
        send_frame(make_frame(16'h8000, 16'h7FFF, 1'b1));
        send_frame(make_frame(16'hFF01, 16'hFF00, 1'b0));
        send_frame(make_frame(16'h00FF, 16'h0100, 1'b0));
        send_frame(make_frame(16'hFFFF, 16'h0000, 1'b0));

        for (int p = 0; p < 9; p++)
        begin
            settle();
            c = make_cfg(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         pick_rate(), pick_rate());
            if (p == 4)
            begin
                c.target_rate = RATE_W'(192000);
                c.source_rate = RATE_W'($urandom_range(1, 30000));
            end
            if (p == 8)
            begin
                c.target_rate = RATE_W'($urandom_range(1, 2000));
                c.source_rate = RATE_W'(192000);
            end
            apply_settings(c);
            steady = (p == 3 || p == 7);
            for (int n = 0; n < 27; n++)
                send_frame(make_frame(pick_sample(), pick_sample(),
                                      $urandom_range(0, 9) == 0));
            steady = 1'b0;
        end

        settle();
        if (copies.errors == 0)
            $display("pcm_zero_order_hold_resampler_top test passed");
        else
            $display("pcm_zero_order_hold_resampler_top test failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("pcm_zero_order_hold_resampler_top test failed");
        $finish;
    end

endmodule
